// File: hw/rtl/integer_matrix_multiply_defines.svh
// ----------------------------------------------------------------------------
// integer matrix multiply assertion macros
// shared assertion forms, sampled on clock and held off during reset
// ----------------------------------------------------------------------------
`ifndef INTEGER_MATRIX_MULTIPLY_DEFINES_SVH
`define INTEGER_MATRIX_MULTIPLY_DEFINES_SVH

// same-cycle implication
`define IMM_ASSERT_HOLDS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IMM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/imm_pkg.sv
// ----------------------------------------------------------------------------
// imm_pkg
// types, codes and helpers shared by the integer matrix multiply block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package imm_pkg;

   localparam int DATA_W    = 32;
   localparam int IDX_W     = 3;
   localparam int DIM_W     = 4;
   localparam int KIND_W    = 2;
   localparam int CSR_IDX_W = 2;

   localparam int MAX_DIM_DEF = 8;
   localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD_A = 2'd0,
      KIND_LOAD_B = 2'd1,
      KIND_START  = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROWS_M  = 2'd0,
      CSR_INNER_N = 2'd1,
      CSR_COLS_K  = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   // one term of a dot product on its way through the mac
   typedef struct packed {
      logic vld;
      logic first;
      logic last;
   } mac_ctrl_type;

   // zero acts as one, anything above the limit acts as the limit
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] lim);
      logic [DIM_W-1:0] d;
      d = v;
      if (d == '0) begin
         d = {{(DIM_W-1){1'b0}}, 1'b1};
      end
      if (d > lim) begin
         d = lim;
      end
      return d;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/imm_channels.sv
// ----------------------------------------------------------------------------
// imm channels
// valid/ready channels for request items, result items and register writes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface imm_req_if;
   logic                              valid;
   logic                              ready;
   logic [imm_pkg::KIND_W-1:0]        kind;
   logic [imm_pkg::IDX_W-1:0]         row;
   logic [imm_pkg::IDX_W-1:0]         col;
   logic signed [imm_pkg::DATA_W-1:0] value;

   modport source (output valid, kind, row, col, value, input ready);
   modport sink   (input valid, kind, row, col, value, output ready);
endinterface

interface imm_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [imm_pkg::IDX_W-1:0]         out_row;
   logic [imm_pkg::IDX_W-1:0]         out_col;
   logic signed [imm_pkg::DATA_W-1:0] product;
   logic                              last;

   modport source (output valid, out_row, out_col, product, last, input ready);
   modport sink   (input valid, out_row, out_col, product, last, output ready);
endinterface

interface imm_csr_if;
   logic                          valid;
   logic                          ready;
   logic [imm_pkg::CSR_IDX_W-1:0] index;
   logic [imm_pkg::DIM_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/imm_ram.sv
// ----------------------------------------------------------------------------
// imm_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module imm_ram #(
   parameter int WIDTH = imm_pkg::DATA_W,
   parameter int DEPTH = imm_pkg::MAX_DIM_DEF * imm_pkg::MAX_DIM_DEF,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_W-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic [ADDR_W-1:0]    rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// File: hw/rtl/imm_mac.sv
// ----------------------------------------------------------------------------
// imm_mac
// shared multiply-accumulate unit, one term per cycle, wrapping at 32 bits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module imm_mac (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire imm_pkg::mac_ctrl_type         ctrl,
   input  wire logic [imm_pkg::DATA_W-1:0]    a,
   input  wire logic [imm_pkg::DATA_W-1:0]    b,
   output logic      [imm_pkg::DATA_W-1:0]    acc,
   output logic                               done
);

   imm_pkg::mac_ctrl_type             mul_ctrl_ff;
   logic [imm_pkg::DATA_W-1:0]        mul_ff;
   logic [imm_pkg::DATA_W-1:0]        mul_in;
   logic [imm_pkg::DATA_W-1:0]        acc_ff;
   logic [imm_pkg::DATA_W-1:0]        acc_in;
   logic                              done_ff;
   logic                              done_in;

   // low word of the product only
   assign mul_in  = a * b;
   assign acc_in  = mul_ctrl_ff.first ? mul_ff : acc_ff + mul_ff;
   assign done_in = mul_ctrl_ff.vld & mul_ctrl_ff.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ctrl_ff <= '0;
         done_ff     <= 1'b0;
      end else begin
         mul_ctrl_ff <= ctrl;
         done_ff     <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      mul_ff <= mul_in;
      if (mul_ctrl_ff.vld) begin
         acc_ff <= acc_in;
      end
   end

   assign acc  = acc_ff;
   assign done = done_ff;

endmodule

`default_nettype wire

// File: hw/rtl/integer_matrix_multiply.sv
// ----------------------------------------------------------------------------
// integer_matrix_multiply
// signed 32-bit matrix product c = a * b from two on-chip element stores
// ----------------------------------------------------------------------------
// a load item whose row and col are in range writes one element of a or b. a
// start item walks every element of c in row-major order through one shared
// multiply-accumulate unit fed from the two stores, one term per cycle: each
// element issues its n terms, which pass the ram read, the multiply register
// and the accumulator, before the sum is handed to the output register once
// that register is free. requests are not taken during
// a run. the output register lets the next item in while a result waits.
// register writes take effect at once and belong between runs.
`timescale 1ns / 1ps
`default_nettype none

`include "integer_matrix_multiply_defines.svh"

module integer_matrix_multiply #(
   parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   imm_req_if.sink    req_if,
   imm_rsp_if.source  rsp_if,
   imm_csr_if.sink    csr_if
);

   localparam int CELLS  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int CNT_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DIM_W  = imm_pkg::DIM_W;
   localparam int IDX_W  = imm_pkg::IDX_W;
   localparam int DATA_W = imm_pkg::DATA_W;
   localparam logic [DIM_W-1:0]  DIM_LIM   = DIM_W'(MAX_DIM);
   localparam logic [DIM_W-1:0]  DIM_ONE   = DIM_W'(1);
   localparam logic [ADDR_W-1:0] ADDR_STEP = ADDR_W'(MAX_DIM);

   // size registers
   logic [DIM_W-1:0] rows_m_ff;
   logic [DIM_W-1:0] inner_n_ff;
   logic [DIM_W-1:0] cols_k_ff;

   // sequencer
   imm_pkg::state_type    state_ff;
   imm_pkg::state_type    state_in;
   logic [CNT_W-1:0]      i_ff;
   logic [CNT_W-1:0]      i_in;
   logic [CNT_W-1:0]      j_ff;
   logic [CNT_W-1:0]      j_in;
   logic [CNT_W-1:0]      z_ff;
   logic [CNT_W-1:0]      z_in;
   imm_pkg::mac_ctrl_type issue;
   imm_pkg::mac_ctrl_type issue_ff;

   // output register
   logic              rsp_vld_ff;
   logic              rsp_vld_in;
   logic [IDX_W-1:0]  rsp_row_ff;
   logic [IDX_W-1:0]  rsp_col_ff;
   logic [DATA_W-1:0] rsp_prod_ff;
   logic              rsp_last_ff;
   logic              load_rsp;

   logic              req_acc;
   logic              start_acc;
   logic              in_range;
   logic              we_a;
   logic              we_b;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr_a;
   logic [ADDR_W-1:0] rd_addr_b;
   logic [DATA_W-1:0] rd_data_a;
   logic [DATA_W-1:0] rd_data_b;
   logic [DATA_W-1:0] mac_acc;
   logic              mac_done;
   logic              z_last;
   logic              j_last;
   logic              i_last;
   logic              out_free;

   // request side
   assign req_if.ready = (state_ff == imm_pkg::ST_IDLE);
   assign req_acc      = req_if.valid & req_if.ready;
   assign start_acc    = req_acc & (req_if.kind == imm_pkg::KIND_START);
   assign in_range     = (DIM_W'(req_if.row) < DIM_LIM) & (DIM_W'(req_if.col) < DIM_LIM);
   assign we_a         = req_acc & in_range & (req_if.kind == imm_pkg::KIND_LOAD_A);
   assign we_b         = req_acc & in_range & (req_if.kind == imm_pkg::KIND_LOAD_B);
   assign wr_addr      = ADDR_W'(req_if.row) * ADDR_STEP + ADDR_W'(req_if.col);

   // register port
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_m_ff  <= imm_pkg::clamp_dim(imm_pkg::DIM_RESET, DIM_LIM);
         inner_n_ff <= imm_pkg::clamp_dim(imm_pkg::DIM_RESET, DIM_LIM);
         cols_k_ff  <= imm_pkg::clamp_dim(imm_pkg::DIM_RESET, DIM_LIM);
      end else if (csr_if.valid) begin
         case (csr_if.index)
            imm_pkg::CSR_ROWS_M: begin
               rows_m_ff <= imm_pkg::clamp_dim(csr_if.data, DIM_LIM);
            end
            imm_pkg::CSR_INNER_N: begin
               inner_n_ff <= imm_pkg::clamp_dim(csr_if.data, DIM_LIM);
            end
            imm_pkg::CSR_COLS_K: begin
               cols_k_ff <= imm_pkg::clamp_dim(csr_if.data, DIM_LIM);
            end
            default: begin
            end
         endcase
      end
   end

   // loop bounds
   assign z_last   = (DIM_W'(z_ff) + DIM_ONE == inner_n_ff);
   assign j_last   = (DIM_W'(j_ff) + DIM_ONE == cols_k_ff);
   assign i_last   = (DIM_W'(i_ff) + DIM_ONE == rows_m_ff);
   assign out_free = ~rsp_vld_ff | rsp_if.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         imm_pkg::ST_IDLE: begin
            if (start_acc) begin
               state_in = imm_pkg::ST_RUN;
            end
         end
         imm_pkg::ST_RUN: begin
            if (z_last) begin
               state_in = imm_pkg::ST_DRAIN;
            end
         end
         imm_pkg::ST_DRAIN: begin
            if (mac_done) begin
               state_in = imm_pkg::ST_EMIT;
            end
         end
         imm_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = (i_last & j_last) ? imm_pkg::ST_IDLE : imm_pkg::ST_RUN;
            end
         end
         default: begin
            state_in = imm_pkg::ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      i_in     = i_ff;
      j_in     = j_ff;
      z_in     = z_ff;
      issue    = '0;
      load_rsp = 1'b0;
      case (state_ff)
         imm_pkg::ST_IDLE: begin
            if (start_acc) begin
               i_in = '0;
               j_in = '0;
               z_in = '0;
            end
         end
         imm_pkg::ST_RUN: begin
            issue.vld   = 1'b1;
            issue.first = (z_ff == '0);
            issue.last  = z_last;
            z_in        = z_last ? '0 : z_ff + CNT_W'(1);
         end
         imm_pkg::ST_EMIT: begin
            if (out_free) begin
               load_rsp = 1'b1;
               if (j_last) begin
                  j_in = '0;
                  if (!i_last) begin
                     i_in = i_ff + CNT_W'(1);
                  end
               end else begin
                  j_in = j_ff + CNT_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= imm_pkg::ST_IDLE;
         issue_ff <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
         z_ff     <= '0;
      end else begin
         state_ff <= state_in;
         issue_ff <= issue;
         i_ff     <= i_in;
         j_ff     <= j_in;
         z_ff     <= z_in;
      end
   end

   // a[i][z] and b[z][j]
   assign rd_addr_a = ADDR_W'(i_ff) * ADDR_STEP + ADDR_W'(z_ff);
   assign rd_addr_b = ADDR_W'(z_ff) * ADDR_STEP + ADDR_W'(j_ff);

   imm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CELLS)
   ) u_store_a (
      .clock   (clock),
      .wr_en   (we_a),
      .wr_addr (wr_addr),
      .wr_data (req_if.value),
      .rd_addr (rd_addr_a),
      .rd_data (rd_data_a)
   );

   imm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CELLS)
   ) u_store_b (
      .clock   (clock),
      .wr_en   (we_b),
      .wr_addr (wr_addr),
      .wr_data (req_if.value),
      .rd_addr (rd_addr_b),
      .rd_data (rd_data_b)
   );

   imm_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (issue_ff),
      .a     (rd_data_a),
      .b     (rd_data_b),
      .acc   (mac_acc),
      .done  (mac_done)
   );

   // output register
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (load_rsp) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_row_ff  <= IDX_W'(i_ff);
         rsp_col_ff  <= IDX_W'(j_ff);
         rsp_prod_ff <= mac_acc;
         rsp_last_ff <= i_last & j_last;
      end
   end

   assign rsp_if.valid   = rsp_vld_ff;
   assign rsp_if.out_row = rsp_row_ff;
   assign rsp_if.out_col = rsp_col_ff;
   assign rsp_if.product = rsp_prod_ff;
   assign rsp_if.last    = rsp_last_ff;

   // checks
   `IMM_ASSERT_HOLDS(a_rsp_in_bounds, rsp_vld_ff, (DIM_W'(rsp_row_ff) < rows_m_ff) && (DIM_W'(rsp_col_ff) < cols_k_ff), "result item outside the configured sizes")
   `IMM_ASSERT_HOLDS(a_emit_drained, state_ff == imm_pkg::ST_EMIT, !issue_ff.vld && !mac_done, "mac still busy at emit")
   `IMM_ASSERT_HOLDS(a_done_in_drain, mac_done, state_ff == imm_pkg::ST_DRAIN, "mac done outside drain")
   `IMM_ASSERT_NEXT(a_bubble_after_last, issue_ff.vld && issue_ff.last, !issue_ff.vld, "element terms overlap")

endmodule

`default_nettype wire
